### rtl/core/clfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfm_pkg
// Shared constants and types of the clamped line fit core.
// ----------------------------------------------------------------------------
package clfm_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int X_W   = 16;
  localparam int Y_W   = 32;
  localparam int SX_W  = X_W + CNT_W;
  localparam int SY_W  = Y_W + CNT_W;
  localparam int SXX_W = 2 * X_W + CNT_W;
  localparam int SXY_W = X_W + Y_W + CNT_W;

  localparam int OP_W  = 64;
  localparam int NUM_W = 128;

  localparam int SLOPE_W = 63;
  localparam int ICPT_W  = 32;
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 2;
  localparam int CFG_W   = 32;
  localparam int ITER_W  = 16;

  localparam logic [KIND_W-1:0] KIND_FULL   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLAT   = 2'd2;

  localparam logic [IDX_W-1:0] REG_MIN_PROG  = 2'd0;
  localparam logic [IDX_W-1:0] REG_MIN_INSTR = 2'd1;
  localparam logic [IDX_W-1:0] REG_ITER      = 2'd2;

  typedef struct packed {
    logic                  en;
    logic [ADDR_W-1:0]     addr;
    logic [X_W+Y_W-1:0]    data;
  } ram_wr_t;

endpackage

### rtl/core/clfm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfm_if
// Point, result and register write channels of the line fit core.
// ----------------------------------------------------------------------------
interface clfm_pt_if;
  logic        valid;
  logic        ready;
  logic [15:0] repeat_count;
  logic [31:0] energy;
  logic        last_point;
  modport source (output valid, repeat_count, energy, last_point, input ready);
  modport sink   (input valid, repeat_count, energy, last_point, output ready);
endinterface

interface clfm_fit_if;
  logic        valid;
  logic        ready;
  logic [62:0] slope_out;
  logic [31:0] intercept_out;
  logic [1:0]  fit_kind;
  modport source (output valid, slope_out, intercept_out, fit_kind, input ready);
  modport sink   (input valid, slope_out, intercept_out, fit_kind, output ready);
endinterface

interface clfm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/clamped_line_fit_with_median_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_line_fit_with_median_core
// Least-squares line fit over a stored point series, median fallback, clamps.
//
// points: one transfer per point, taken only while the core is idle;
// points beyond MAX_POINTS are dropped. A point with last_point set ends the
// series and starts the fit; points.ready stays low until the result is
// registered. cfg: register writes, always ready; the user must use them only
// while idle, and the core itself does not enforce it. fit: one result per
// series, held in an output register until taken. The fit sums the store,
// forms up to seven products on the shift-add multiplier and up to three
// quotients on the serial divider, then registers the result. The median
// fallback (single point or zero x variance) scans the store once per
// candidate. Reset empties the series, sets the bounds to zero and the
// iteration count to one. A stalled fit output keeps the core busy in its
// final state until the result is taken.
// ----------------------------------------------------------------------------
module clamped_line_fit_with_median_core
  import clfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  clfm_pt_if.sink     points,
  clfm_fit_if.source  fit,
  clfm_cfg_if.sink    cfg
);

  typedef enum logic [4:0] {
    S_IDLE, S_SUM, S_MUL_NSXX, S_MUL_SXSX, S_MUL_NSXY, S_MUL_SXSY,
    S_DIV_SLOPE, S_DIV_ITER, S_MUL_SYV, S_MUL_CSX, S_MUL_NV, S_DIV_ICPT,
    S_MED_RD, S_MED_LAT, S_MED_SCAN, S_MED_END, S_FINISH
  } state_t;

  localparam logic [SLOPE_W-1:0] SLOPE_MAX = '1;
  localparam logic [ICPT_W-1:0]  ICPT_MAX  = '1;

  state_t               state;
  state_t               prev_state;
  logic [CFG_W-1:0]     min_prog;
  logic [CFG_W-1:0]     min_instr;
  logic [ITER_W-1:0]    iter;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     ci;
  logic [CNT_W-1:0]     lt;
  logic [CNT_W-1:0]     le;
  logic                 pend;
  logic [SX_W-1:0]      sx;
  logic [SY_W-1:0]      sy;
  logic [SXX_W-1:0]     sxx;
  logic [SXY_W-1:0]     sxy;
  logic [OP_W-1:0]      t1;
  logic [OP_W-1:0]      varn;
  logic [OP_W-1:0]      cmag;
  logic                 covneg;
  logic [NUM_W-1:0]     numa;
  logic [NUM_W-1:0]     numr;
  logic [SLOPE_W-1:0]   slope;
  logic [Y_W-1:0]       cand;
  logic [Y_W-1:0]       ma;
  logic [Y_W-1:0]       mb;
  logic [KIND_W-1:0]    kind;
  logic [ICPT_W-1:0]    icpt;
  logic                 mul_start;
  logic                 div_start;
  logic                 mul_done;
  logic                 div_done;
  logic [NUM_W-1:0]     prod;
  logic [NUM_W-1:0]     quo;
  logic [OP_W-1:0]      mul_a;
  logic [OP_W-1:0]      mul_b;
  logic [NUM_W-1:0]     div_n;
  logic [OP_W-1:0]      div_d;
  ram_wr_t              mem_wr;
  logic [ADDR_W-1:0]    rd_addr;
  logic [X_W+Y_W-1:0]   rd_data;
  logic [X_W-1:0]       rx;
  logic [Y_W-1:0]       ry;
  logic [2*X_W-1:0]     xx;
  logic [X_W+Y_W-1:0]   xy;
  logic [CNT_W-1:0]     klo;
  logic [CNT_W-1:0]     khi;
  logic                 pt_acc;
  logic                 room;
  logic [OP_W-1:0]      varn_v;
  logic [SLOPE_W-1:0]   raw;
  logic [Y_W:0]         msum;
  logic [ICPT_W-1:0]    q_icpt;

  clfm_ram u_ram (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  clfm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  clfm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quo   (quo)
  );

  assign points.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign pt_acc       = points.valid && points.ready;
  assign room         = cnt < CNT_W'(MAX_POINTS);

  // start pulse on the first cycle of each multiply or divide state
  assign mul_start = (state != prev_state) &&
                     (state inside {S_MUL_NSXX, S_MUL_SXSX, S_MUL_NSXY, S_MUL_SXSY,
                                    S_MUL_SYV, S_MUL_CSX, S_MUL_NV});
  assign div_start = (state != prev_state) &&
                     (state inside {S_DIV_SLOPE, S_DIV_ITER, S_DIV_ICPT});

  assign mem_wr.en   = pt_acc && room;
  assign mem_wr.addr = cnt[ADDR_W-1:0];
  assign mem_wr.data = {points.energy, points.repeat_count};

  assign rd_addr = (state == S_MED_RD) ? ci[ADDR_W-1:0] : idx[ADDR_W-1:0];
  assign rx      = rd_data[X_W-1:0];
  assign ry      = rd_data[X_W+Y_W-1:X_W];
  assign xx      = rx * rx;
  assign xy      = rx * ry;
  assign klo     = (n - 1'b1) >> 1;
  assign khi     = n >> 1;
  assign varn_v  = t1 - prod[OP_W-1:0];
  assign raw     = (quo[NUM_W-1:SLOPE_W] != '0) ? SLOPE_MAX : quo[SLOPE_W-1:0];
  assign msum    = {1'b0, ma} + {1'b0, mb};
  assign q_icpt  = (quo[NUM_W-1:ICPT_W] != '0) ? ICPT_MAX : quo[ICPT_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_NSXX: begin mul_a = OP_W'(n);    mul_b = OP_W'(sxx);  end
      S_MUL_SXSX: begin mul_a = OP_W'(sx);   mul_b = OP_W'(sx);   end
      S_MUL_NSXY: begin mul_a = OP_W'(n);    mul_b = OP_W'(sxy);  end
      S_MUL_SXSY: begin mul_a = OP_W'(sx);   mul_b = OP_W'(sy);   end
      S_MUL_SYV:  begin mul_a = OP_W'(sy);   mul_b = varn;        end
      S_MUL_CSX:  begin mul_a = cmag;        mul_b = OP_W'(sx);   end
      S_MUL_NV:   begin mul_a = OP_W'(n);    mul_b = varn;        end
      default:    begin mul_a = '0;          mul_b = '0;          end
    endcase
  end

  always_comb begin
    div_n = '0;
    div_d = OP_W'(1);
    case (state)
      S_DIV_SLOPE: begin
        div_n = NUM_W'(cmag) << 16;
        div_d = varn;
      end
      S_DIV_ITER: begin
        div_n = NUM_W'(slope);
        div_d = (iter == '0) ? OP_W'(1) : OP_W'(iter);
      end
      S_DIV_ICPT: begin
        div_n = numr;
        div_d = t1;
      end
      default: begin
        div_n = '0;
        div_d = OP_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev_state <= S_IDLE;
      cnt        <= '0;
      min_prog   <= '0;
      min_instr  <= '0;
      iter       <= ITER_W'(1);
      fit.valid  <= 1'b0;
      pend       <= 1'b0;
    end else begin
      prev_state <= state;
      if (state == S_FINISH && (!fit.valid || fit.ready)) begin
        fit.valid <= 1'b1;
      end else if (fit.ready) begin
        fit.valid <= 1'b0;
      end
      if (cfg.valid) begin
        case (cfg.index)
          REG_MIN_PROG:  min_prog  <= cfg.data;
          REG_MIN_INSTR: min_instr <= cfg.data;
          REG_ITER:      iter      <= cfg.data[ITER_W-1:0];
          default:       ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (pt_acc) begin
            if (points.last_point) begin
              n     <= cnt + CNT_W'(room);
              cnt   <= '0;
              sx    <= '0;
              sy    <= '0;
              sxx   <= '0;
              sxy   <= '0;
              idx   <= '0;
              pend  <= 1'b0;
              state <= S_SUM;
            end else if (room) begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_SUM: begin
          if (idx < n) begin
            idx <= idx + 1'b1;
          end
          pend <= idx < n;
          if (pend) begin
            sx  <= sx + SX_W'(rx);
            sy  <= sy + SY_W'(ry);
            sxx <= sxx + SXX_W'(xx);
            sxy <= sxy + SXY_W'(xy);
          end
          if (idx == n && !pend) begin
            state <= S_MUL_NSXX;
          end
        end
        S_MUL_NSXX: begin
          if (mul_done) begin
            t1    <= prod[OP_W-1:0];
            state <= S_MUL_SXSX;
          end
        end
        S_MUL_SXSX: begin
          if (mul_done) begin
            varn <= varn_v;
            ci   <= '0;
            ma   <= '0;
            mb   <= '0;
            if (n == CNT_W'(1)) begin
              kind  <= KIND_SINGLE;
              slope <= '0;
              state <= S_MED_RD;
            end else if (varn_v == '0) begin
              kind  <= KIND_FLAT;
              slope <= SLOPE_W'(min_instr);
              state <= S_MED_RD;
            end else begin
              kind  <= KIND_FULL;
              state <= S_MUL_NSXY;
            end
          end
        end
        S_MUL_NSXY: begin
          if (mul_done) begin
            t1    <= prod[OP_W-1:0];
            state <= S_MUL_SXSY;
          end
        end
        S_MUL_SXSY: begin
          if (mul_done) begin
            covneg <= t1 < prod[OP_W-1:0];
            cmag   <= (t1 < prod[OP_W-1:0]) ? prod[OP_W-1:0] - t1 : t1 - prod[OP_W-1:0];
            if (t1 <= prod[OP_W-1:0]) begin
              slope <= SLOPE_W'(min_instr);
              state <= S_MUL_SYV;
            end else begin
              state <= S_DIV_SLOPE;
            end
          end
        end
        S_DIV_SLOPE: begin
          if (div_done) begin
            if (raw <= SLOPE_W'(min_instr)) begin
              slope <= SLOPE_W'(min_instr);
              state <= S_MUL_SYV;
            end else begin
              slope <= raw;
              state <= S_DIV_ITER;
            end
          end
        end
        S_DIV_ITER: begin
          if (div_done) begin
            slope <= quo[SLOPE_W-1:0];
            state <= S_MUL_SYV;
          end
        end
        S_MUL_SYV: begin
          if (mul_done) begin
            numa  <= prod;
            state <= S_MUL_CSX;
          end
        end
        S_MUL_CSX: begin
          if (mul_done) begin
            if (covneg) begin
              numr <= numa + prod;
            end else if (numa < prod) begin
              numr <= '0;
            end else begin
              numr <= numa - prod;
            end
            state <= S_MUL_NV;
          end
        end
        S_MUL_NV: begin
          if (mul_done) begin
            t1    <= prod[OP_W-1:0];
            state <= S_DIV_ICPT;
          end
        end
        S_DIV_ICPT: begin
          if (div_done) begin
            icpt  <= (q_icpt < min_prog) ? min_prog : q_icpt;
            state <= S_FINISH;
          end
        end
        S_MED_RD: begin
          state <= S_MED_LAT;
        end
        S_MED_LAT: begin
          cand  <= ry;
          idx   <= '0;
          pend  <= 1'b0;
          lt    <= '0;
          le    <= '0;
          state <= S_MED_SCAN;
        end
        S_MED_SCAN: begin
          if (idx < n) begin
            idx <= idx + 1'b1;
          end
          pend <= idx < n;
          if (pend) begin
            if (ry < cand) begin
              lt <= lt + 1'b1;
            end
            if (ry <= cand) begin
              le <= le + 1'b1;
            end
          end
          if (idx == n && !pend) begin
            if (lt <= klo && le > klo) begin
              ma <= cand;
            end
            if (lt <= khi && le > khi) begin
              mb <= cand;
            end
            if (ci + 1'b1 == n) begin
              state <= S_MED_END;
            end else begin
              ci    <= ci + 1'b1;
              state <= S_MED_RD;
            end
          end
        end
        S_MED_END: begin
          icpt  <= (msum[Y_W:1] < min_prog) ? min_prog : msum[Y_W:1];
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!fit.valid || fit.ready) begin
            fit.slope_out     <= slope;
            fit.intercept_out <= icpt;
            fit.fit_kind      <= kind;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_single_slope: assert property (@(posedge clk) disable iff (rst)
    (fit.valid && fit.fit_kind == KIND_SINGLE) |-> fit.slope_out == '0)
    else $error("single point result with nonzero slope");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(fit.valid) |-> $past(state) == S_FINISH)
    else $error("result raised outside final state");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !mem_wr.en)
    else $error("store written while fitting");

endmodule

### rtl/core/clfm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfm_ram
// Point store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module clfm_ram
  import clfm_pkg::*;
(
  input  logic                clk,
  input  ram_wr_t             wr,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [X_W+Y_W-1:0]  rd_data
);

  logic [X_W+Y_W-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/clfm_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfm_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module clfm_mul
  import clfm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [OP_W-1:0]  a,
  input  logic [OP_W-1:0]  b,
  output logic             done,
  output logic [NUM_W-1:0] prod
);

  logic [NUM_W-1:0]        mc;
  logic [OP_W-1:0]         mb;
  logic [$clog2(OP_W)-1:0] cnt;
  logic                    run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prod <= '0;
        mc   <= NUM_W'(a);
        mb   <= b;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        if (mb[0]) begin
          prod <= prod + mc;
        end
        mc  <= mc << 1;
        mb  <= mb >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/clfm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clfm_div
// Restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module clfm_div
  import clfm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [OP_W-1:0]  den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic [NUM_W-1:0]         nsh;
  logic [OP_W-1:0]          dr;
  logic [OP_W-1:0]          rem;
  logic [$clog2(NUM_W)-1:0] cnt;
  logic                     run;
  logic [OP_W:0]            trial;
  logic                     ge;

  assign trial = {rem, nsh[NUM_W-1]};
  assign ge    = trial >= {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nsh <= num;
        dr  <= den;
        rem <= '0;
        quo <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? OP_W'(trial - {1'b0, dr}) : trial[OP_W-1:0];
        quo <= {quo[NUM_W-2:0], ge};
        nsh <= nsh << 1;
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
